FILE: sv/framed_param_message_parser_core_macros.svh
// Assertion macros for the framed parameter message parser.
// Included by framed_param_message_parser_core; no other dependencies.
`ifndef FRAMED_PARAM_MESSAGE_PARSER_CORE_MACROS_SVH
`define FRAMED_PARAM_MESSAGE_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FPMP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpmp assertion failed");
`define FPMP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpmp assertion failed");
`else
`define FPMP_ASSERT_IMP(label, clk, rst, ante, cons)
`define FPMP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/fpmp_pkg.sv
// Types and constants of the framed parameter message parser.
// No dependencies.
package fpmp_pkg;

   localparam logic       CSR_START_MARKER = 1'b0;
   localparam logic       CSR_END_MARKER   = 1'b1;

   localparam logic [7:0] START_MARKER_RST = 8'd2;
   localparam logic [7:0] END_MARKER_RST   = 8'd3;

   localparam logic [1:0] PH_START   = 2'd0;
   localparam logic [1:0] PH_CODE    = 2'd1;
   localparam logic [1:0] PH_PENDING = 2'd2;
   localparam logic [1:0] PH_VALUE   = 2'd3;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
   localparam logic [2:0] ST_BAD_FRAME    = 3'd2;
   localparam logic [2:0] ST_EMPTY        = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE   = 3'd4;
   localparam logic [2:0] ST_UNKNOWN_CODE = 3'd5;
   localparam logic [2:0] ST_SHORT_VALUE  = 3'd6;
   localparam logic [2:0] ST_BAD_VALUE    = 3'd7;

   localparam logic [7:0] CODE_FREQ  = 8'h46;  // 'F'
   localparam logic [7:0] CODE_SENS  = 8'h53;  // 'S'
   localparam logic [7:0] CODE_CHAN  = 8'h43;  // 'C'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [13:0] FREQ_MIN = 14'd100;
   localparam logic [13:0] FREQ_MAX = 14'd5000;
   localparam logic [13:0] SENS_MAX = 14'd3;
   localparam logic [13:0] CHAN_MAX = 14'd16;

   // fields from the lowest bit up: status first
   typedef struct packed {
      logic [5:0]  pad;
      logic        channel_present;
      logic [4:0]  channel;
      logic        sensitivity_present;
      logic [1:0]  sensitivity;
      logic        frequency_present;
      logic [12:0] frequency;
      logic [2:0]  status;
   } result_type;

   function automatic logic [2:0] code_len(input logic [7:0] code);
      logic [2:0] len;
      len = 3'd0;
      if (code == CODE_FREQ) len = 3'd4;
      else if (code == CODE_SENS) len = 3'd1;
      else if (code == CODE_CHAN) len = 3'd2;
      return len;
   endfunction

endpackage

FILE: sv/framed_param_message_parser_core.sv
// Framed parameter message parser: byte stream in, one result per message out.
// Depends on fpmp_pkg and framed_param_message_parser_core_macros.svh.
//
//   channel | direction | fields
//   req_    | in        | tdata: in_byte[7:0]; tlast: is_last
//   rsp_    | out       | tdata: status, frequency, presence flags, etc.
//   csr_    | in        | we, addr (0 start marker, 1 end marker), wdata
//
// One byte per cycle while req_tready is high; the parse state updates in the accept cycle.
// The result register loads on the last byte and shows it the next cycle.
// req_tready stays high unless the result register is full and stalled.
// Synchronous reset clears the parse state and result valid, and restores the markers.
`include "framed_param_message_parser_core_macros.svh"

module framed_param_message_parser_core
   import fpmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // status[2:0], frequency[15:3], frequency_present[16],
                                    // sensitivity[18:17], sensitivity_present[19],
                                    // channel[24:20], channel_present[25], zeros
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]  start_marker_ff, end_marker_ff;
   logic [1:0]  bytes_ff, bytes_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [2:0]  vcnt_ff, vcnt_in;
   logic [13:0] acc_ff, acc_in;
   logic        sign_ff, sign_in, neg_ff, neg_in, digit_ff, digit_in;
   logic        mal_ff, mal_in;
   logic [2:0]  err_ff, err_in;
   logic        start_bad_ff, start_bad_in;
   logic        payload_ff, payload_in;
   logic [12:0] freq_ff, freq_in;
   logic [1:0]  sens_ff, sens_in;
   logic [4:0]  chan_ff, chan_in;
   logic [2:0]  pres_ff, pres_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        req_acc;
   logic [7:0]  b;
   logic        first_val;
   logic [2:0]  cur_cnt, new_cnt;
   logic [13:0] cur_acc, acc_x10, new_acc;
   logic        cur_sign, cur_neg, cur_digit, cur_mal;
   logic        is_sign, is_digit;
   logic        new_sign, new_neg, new_digit, new_mal;
   logic        finish, val_ok;
   logic [2:0]  status;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign b          = req_tdata;

   // value character step; a code still pending starts a fresh value
   always_comb begin
      first_val = (phase_ff == PH_PENDING);
      cur_cnt   = first_val ? 3'd0  : vcnt_ff;
      cur_acc   = first_val ? 14'd0 : acc_ff;
      cur_sign  = !first_val && sign_ff;
      cur_neg   = !first_val && neg_ff;
      cur_digit = !first_val && digit_ff;
      cur_mal   = !first_val && mal_ff;
      is_sign   = (cur_cnt == 3'd0) && (b == CHAR_PLUS || b == CHAR_MINUS);
      is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      acc_x10   = {cur_acc[10:0], 3'b000} + {cur_acc[12:0], 1'b0};
      new_acc   = (!is_sign && is_digit) ? acc_x10 + {10'd0, b[3:0]} : cur_acc;
      new_sign  = cur_sign || is_sign;
      new_neg   = cur_neg || (is_sign && b == CHAR_MINUS);
      new_digit = cur_digit || (!is_sign && is_digit);
      new_mal   = cur_mal || (!is_sign && !is_digit);
      new_cnt   = cur_cnt + 3'd1;
      finish    = new_cnt >= code_len(code_ff);
      val_ok    = !new_mal && new_digit && !new_neg;
      priority if (code_ff == CODE_FREQ) begin
         // last character is a digit whenever val_ok holds, so it is the ones digit
         val_ok = val_ok && new_acc >= FREQ_MIN && new_acc <= FREQ_MAX && b == CHAR_ZERO;
      end else if (code_ff == CODE_SENS) begin
         val_ok = val_ok && !new_sign && new_acc >= 14'd1 && new_acc <= SENS_MAX;
      end else begin
         val_ok = val_ok && new_acc >= 14'd1 && new_acc <= CHAN_MAX;
      end
   end

   always_comb begin
      priority if (bytes_ff == 2'd0) status = ST_TOO_SHORT;
      else if (start_bad_ff || b != end_marker_ff) status = ST_BAD_FRAME;
      else if (!payload_ff) status = ST_EMPTY;
      else if (err_ff != ST_OK) status = err_ff;
      else if (phase_ff == PH_PENDING) status = ST_INCOMPLETE;
      else if (phase_ff == PH_VALUE) status = ST_SHORT_VALUE;
      else status = ST_OK;
   end

   always_comb begin
      bytes_in     = bytes_ff;
      phase_in     = phase_ff;
      code_in      = code_ff;
      vcnt_in      = vcnt_ff;
      acc_in       = acc_ff;
      sign_in      = sign_ff;
      neg_in       = neg_ff;
      digit_in     = digit_ff;
      mal_in       = mal_ff;
      err_in       = err_ff;
      start_bad_in = start_bad_ff;
      payload_in   = payload_ff;
      freq_in      = freq_ff;
      sens_in      = sens_ff;
      chan_in      = chan_ff;
      pres_in      = pres_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      if (req_acc && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = status;
         if (status == ST_OK) begin
            rsp_in.frequency           = pres_ff[0] ? freq_ff : 13'd0;
            rsp_in.frequency_present   = pres_ff[0];
            rsp_in.sensitivity         = pres_ff[1] ? sens_ff : 2'd0;
            rsp_in.sensitivity_present = pres_ff[1];
            rsp_in.channel             = pres_ff[2] ? chan_ff : 5'd0;
            rsp_in.channel_present     = pres_ff[2];
         end
         bytes_in     = 2'd0;
         phase_in     = PH_START;
         code_in      = 8'd0;
         vcnt_in      = 3'd0;
         acc_in       = 14'd0;
         sign_in      = 1'b0;
         neg_in       = 1'b0;
         digit_in     = 1'b0;
         mal_in       = 1'b0;
         err_in       = ST_OK;
         start_bad_in = 1'b0;
         payload_in   = 1'b0;
         freq_in      = 13'd0;
         sens_in      = 2'd0;
         chan_in      = 5'd0;
         pres_in      = 3'd0;
      end else if (req_acc) begin
         if (bytes_ff == 2'd0) begin
            start_bad_in = (b != start_marker_ff);
            bytes_in     = 2'd1;
            phase_in     = PH_CODE;
         end else begin
            if (bytes_ff != 2'd3) bytes_in = bytes_ff + 2'd1;
            payload_in = 1'b1;
            if (err_ff == ST_OK) begin
               if (phase_ff == PH_CODE) begin
                  code_in  = b;
                  phase_in = PH_PENDING;
               end else if (phase_ff == PH_PENDING && code_len(code_ff) == 3'd0) begin
                  err_in = ST_UNKNOWN_CODE;
               end else begin
                  vcnt_in  = new_cnt;
                  acc_in   = new_acc;
                  sign_in  = new_sign;
                  neg_in   = new_neg;
                  digit_in = new_digit;
                  mal_in   = new_mal;
                  phase_in = PH_VALUE;
                  if (finish) begin
                     phase_in = PH_CODE;
                     vcnt_in  = 3'd0;
                     if (!val_ok) begin
                        err_in = ST_BAD_VALUE;
                     end else if (code_ff == CODE_FREQ) begin
                        freq_in    = new_acc[12:0];
                        pres_in[0] = 1'b1;
                     end else if (code_ff == CODE_SENS) begin
                        sens_in    = new_acc[1:0];
                        pres_in[1] = 1'b1;
                     end else begin
                        chan_in    = new_acc[4:0];
                        pres_in[2] = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default:          start_marker_ff <= start_marker_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff     <= 2'd0;
         phase_ff     <= PH_START;
         code_ff      <= 8'd0;
         vcnt_ff      <= 3'd0;
         acc_ff       <= 14'd0;
         sign_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         digit_ff     <= 1'b0;
         mal_ff       <= 1'b0;
         err_ff       <= ST_OK;
         start_bad_ff <= 1'b0;
         payload_ff   <= 1'b0;
         pres_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bytes_ff     <= bytes_in;
         phase_ff     <= phase_in;
         code_ff      <= code_in;
         vcnt_ff      <= vcnt_in;
         acc_ff       <= acc_in;
         sign_ff      <= sign_in;
         neg_ff       <= neg_in;
         digit_ff     <= digit_in;
         mal_ff       <= mal_in;
         err_ff       <= err_in;
         start_bad_ff <= start_bad_in;
         payload_ff   <= payload_in;
         pres_ff      <= pres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      sens_ff <= sens_in;
      chan_ff <= chan_in;
      rsp_ff  <= rsp_in;
   end

   `FPMP_ASSERT_NXT(a_last_gives_result, clock, reset, req_acc && req_tlast, rsp_valid_ff)
   `FPMP_ASSERT_NXT(a_first_leaves_start, clock, reset, req_acc && !req_tlast, phase_ff != PH_START)
   `FPMP_ASSERT_IMP(a_err_needs_payload, clock, reset, err_ff != ST_OK, payload_ff && bytes_ff != 2'd0)
   `FPMP_ASSERT_IMP(a_fail_no_presence, clock, reset, rsp_valid_ff && rsp_ff.status != ST_OK,
                    !rsp_ff.frequency_present && !rsp_ff.sensitivity_present && !rsp_ff.channel_present)

endmodule

FILE: tb/testbench.sv
// Testbench for framed_param_message_parser_core: byte messages in, one status item out.
// Holds its own parse model in a small scoreboard class; depends on fpmp_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fpmp_pkg::*;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam int         HOLD_CYCLES = 300;

   class message_scoreboard;
      logic [7:0]  start_marker;
      logic [7:0]  end_marker;
      logic [1:0]  byte_count;
      logic [1:0]  phase;
      logic [7:0]  code;
      logic [2:0]  taken;
      logic [13:0] accum;
      logic        sign_seen;
      logic        negative;
      logic        digit_seen;
      logic        malformed;
      logic [2:0]  first_error;
      logic        start_bad;
      logic        payload_seen;
      logic [12:0] frequency;
      logic [1:0]  sensitivity;
      logic [4:0]  channel;
      logic        have_freq;
      logic        have_sens;
      logic        have_chan;
      result_type  pending_results[$];
      int          mismatches;
      int          messages;
      int          bytes_taken;
      int          status_count[8];

      function new();
         start_marker = START_MARKER_RST;
         end_marker   = END_MARKER_RST;
         mismatches   = 0;
         messages     = 0;
         bytes_taken  = 0;
         foreach (status_count[i]) status_count[i] = 0;
         clear_message();
      endfunction

      static function int value_length(input logic [7:0] c);
         if (c == CODE_FREQ) return 4;
         if (c == CODE_SENS) return 1;
         if (c == CODE_CHAN) return 2;
         return 0;
      endfunction

      function void set_marker(input logic idx, input logic [7:0] value);
         if (idx == CSR_START_MARKER) start_marker = value;
         else end_marker = value;
      endfunction

      function void clear_value();
         taken      = '0;
         accum      = '0;
         sign_seen  = 1'b0;
         negative   = 1'b0;
         digit_seen = 1'b0;
         malformed  = 1'b0;
      endfunction

      function void clear_message();
         byte_count   = '0;
         phase        = PH_START;
         code         = '0;
         clear_value();
         first_error  = ST_OK;
         start_bad    = 1'b0;
         payload_seen = 1'b0;
         frequency    = '0;
         sensitivity  = '0;
         channel      = '0;
         have_freq    = 1'b0;
         have_sens    = 1'b0;
         have_chan    = 1'b0;
      endfunction

      function void close_value();
         logic ok;
         ok = !malformed && digit_seen && !negative;
         if (code == CODE_FREQ) begin
            ok = ok && accum >= FREQ_MIN && accum <= FREQ_MAX && (accum % 10) == 0;
            if (ok) begin
               frequency = accum[12:0];
               have_freq = 1'b1;
            end
         end else if (code == CODE_SENS) begin
            ok = ok && !sign_seen && accum >= 1 && accum <= SENS_MAX;
            if (ok) begin
               sensitivity = accum[1:0];
               have_sens   = 1'b1;
            end
         end else begin
            ok = ok && accum >= 1 && accum <= CHAN_MAX;
            if (ok) begin
               channel   = accum[4:0];
               have_chan = 1'b1;
            end
         end
         if (!ok) first_error = ST_BAD_VALUE;
         phase = PH_CODE;
         clear_value();
      endfunction

      function void take_char(input logic [7:0] b);
         logic [17:0] wide;
         if (taken == 0 && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
            sign_seen = 1'b1;
            if (b == CHAR_MINUS) negative = 1'b1;
         end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            wide       = accum * 18'd10 + 18'(b - CHAR_ZERO);
            accum      = wide[13:0];
            digit_seen = 1'b1;
         end else begin
            malformed = 1'b1;
         end
         taken = taken + 3'd1;
         if (int'(taken) >= value_length(code)) close_value();
      endfunction

      function void note_byte(input logic [7:0] b, input logic last);
         result_type r;
         bytes_taken++;
         if (!last) begin
            if (byte_count == 0) begin
               start_bad  = (b != start_marker);
               byte_count = 2'd1;
               phase      = PH_CODE;
               return;
            end
            if (byte_count < 3) byte_count = byte_count + 2'd1;
            payload_seen = 1'b1;
            if (first_error != ST_OK) return;
            case (phase)
               PH_CODE: begin
                  code  = b;
                  phase = PH_PENDING;
               end
               PH_PENDING: begin
                  if (value_length(code) == 0) first_error = ST_UNKNOWN_CODE;
                  else begin
                     phase = PH_VALUE;
                     clear_value();
                     take_char(b);
                  end
               end
               default: take_char(b);
            endcase
            return;
         end
         r = '0;
         if (byte_count == 0) r.status = ST_TOO_SHORT;
         else if (start_bad || b != end_marker) r.status = ST_BAD_FRAME;
         else if (!payload_seen) r.status = ST_EMPTY;
         else if (first_error != ST_OK) r.status = first_error;
         else if (phase == PH_PENDING) r.status = ST_INCOMPLETE;
         else if (phase == PH_VALUE) r.status = ST_SHORT_VALUE;
         else r.status = ST_OK;
         if (r.status == ST_OK) begin
            if (have_freq) begin
               r.frequency         = frequency;
               r.frequency_present = 1'b1;
            end
            if (have_sens) begin
               r.sensitivity         = sensitivity;
               r.sensitivity_present = 1'b1;
            end
            if (have_chan) begin
               r.channel         = channel;
               r.channel_present = 1'b1;
            end
         end
         pending_results.push_back(r);
         status_count[r.status]++;
         messages++;
         clear_message();
      endfunction

      function string show(input result_type r);
         return $sformatf("st=%0d f=%0d/%0b s=%0d/%0b c=%0d/%0b pad=%h", r.status,
            r.frequency, r.frequency_present, r.sensitivity, r.sensitivity_present,
            r.channel, r.channel_present, r.pad);
      endfunction

      function void check_result(input logic [31:0] data);
         result_type got;
         result_type want;
         got = data;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected item %s", show(got));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.frequency !== want.frequency ||
             got.frequency_present !== want.frequency_present ||
             got.sensitivity !== want.sensitivity ||
             got.sensitivity_present !== want.sensitivity_present ||
             got.channel !== want.channel || got.channel_present !== want.channel_present ||
             got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected %s got %s", show(want), show(got));
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic        csr_addr;
   logic [7:0]  csr_wdata;

   message_scoreboard sb;
   logic [7:0] msg_q[$];
   int send_idle_pct;
   int recv_stall_pct;
   int hold_asks;
   int settings_used;

   framed_param_message_parser_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver: random stalls, plus a long hold-off on request
   int hold_left = 0;
   int hold_seen = 0;
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("framed_param_message_parser_core verification failed");
      $finish;
   end

   function automatic logic [7:0] digit_char(input int d);
      return CHAR_ZERO + 8'(d);
   endfunction

   function automatic void put_digits(input int v, input int n);
      int p;
      p = 1;
      for (int k = 1; k < n; k++) p = p * 10;
      for (int k = 0; k < n; k++) begin
         msg_q.push_back(digit_char((v / p) % 10));
         p = p / 10;
      end
   endfunction

   function automatic logic [7:0] value_char();
      case ($urandom_range(0, 9))
         0: return CHAR_PLUS;
         1: return CHAR_MINUS;
         2: return CHAR_SPACE;
         3: return 8'($urandom_range(0, 255));
         default: return digit_char($urandom_range(0, 9));
      endcase
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 2))
         0: return CODE_FREQ;
         1: return CODE_SENS;
         default: return CODE_CHAN;
      endcase
   endfunction

   function automatic void put_good_record(input logic [7:0] c);
      int v;
      msg_q.push_back(c);
      if (c == CODE_FREQ) begin
         case ($urandom_range(0, 5))
            0: v = 100;
            1: v = 5000;
            default: v = 10 * $urandom_range(10, 500);
         endcase
         if (v < 1000 && $urandom_range(0, 1) == 1) begin
            msg_q.push_back(CHAR_PLUS);
            put_digits(v, 3);
         end else begin
            put_digits(v, 4);
         end
      end else if (c == CODE_SENS) begin
         put_digits($urandom_range(1, 3), 1);
      end else begin
         v = $urandom_range(1, 16);
         if (v < 10 && $urandom_range(0, 1) == 1) begin
            msg_q.push_back(CHAR_PLUS);
            put_digits(v, 1);
         end else begin
            put_digits(v, 2);
         end
      end
   endfunction

   function automatic void put_bad_record(input logic [7:0] c);
      int n;
      n = message_scoreboard::value_length(c);
      msg_q.push_back(c);
      if ($urandom_range(0, 1) == 1) begin
         if (c == CODE_FREQ) put_digits($urandom_range(0, 9999), 4);
         else if (c == CODE_SENS) put_digits($urandom_range(0, 9), 1);
         else put_digits($urandom_range(0, 99), 2);
      end else begin
         for (int k = 0; k < n; k++) msg_q.push_back(value_char());
      end
   endfunction

   function automatic void build_message();
      int kind;
      int n;
      logic [7:0] c;
      msg_q.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 94) begin
         msg_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      msg_q.push_back(sb.start_marker);
      if (kind < 60) begin
         n = $urandom_range(1, 4);
         for (int k = 0; k < n; k++) put_good_record(pick_code());
      end else if (kind < 75) begin
         n = $urandom_range(1, 4);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) put_good_record(pick_code());
            else put_bad_record(pick_code());
         end
      end else if (kind < 82) begin
         n = $urandom_range(0, 2);
         for (int k = 0; k < n; k++) put_good_record(pick_code());
         c = pick_code();
         msg_q.push_back(c);
         n = $urandom_range(0, message_scoreboard::value_length(c) - 1);
         for (int k = 0; k < n; k++) msg_q.push_back(value_char());
      end else if (kind < 86) begin
         if ($urandom_range(0, 1) == 1) put_good_record(pick_code());
         msg_q.push_back(8'($urandom_range(0, 255)));
         n = $urandom_range(0, 3);
         for (int k = 0; k < n; k++) msg_q.push_back(value_char());
      end else if (kind < 90) begin
         if ($urandom_range(0, 1) == 1) msg_q[0] = 8'($urandom_range(0, 255));
         put_good_record(pick_code());
         msg_q.push_back(8'($urandom_range(0, 255)));
         return;
      end else if (kind >= 92) begin
         n = $urandom_range(1, 8);
         for (int k = 0; k < n; k++) msg_q.push_back(8'($urandom_range(0, 255)));
      end
      msg_q.push_back(sb.end_marker);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_message();
      foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_marker(idx, value);
   endtask

   task automatic random_messages(input int byte_budget);
      int sent;
      sent = 0;
      while (sent < byte_budget) begin
         build_message();
         sent += msg_q.size();
         send_message();
      end
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = CSR_START_MARKER;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asks      = 0;
      settings_used  = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: too short, empty, full-range ok, incomplete, unknown code, short value
      msg_q = '{sb.start_marker};
      send_message();
      msg_q = '{sb.start_marker, sb.end_marker};
      send_message();
      msg_q = '{sb.start_marker, CODE_FREQ, digit_char(5), digit_char(0), digit_char(0),
                digit_char(0), CODE_SENS, digit_char(3), CODE_CHAN, digit_char(1),
                digit_char(6), sb.end_marker};
      send_message();
      msg_q = '{sb.start_marker, CHAR_Z, sb.end_marker};
      send_message();
      msg_q = '{sb.start_marker, CHAR_Z, digit_char(1), sb.end_marker};
      send_message();
      msg_q = '{sb.start_marker, CODE_FREQ, digit_char(1), digit_char(2), sb.end_marker};
      send_message();
      random_messages(100);
      drain();

      for (int ph = 1; ph < 8; ph++) begin
         case (ph)
            1: begin
               write_csr(CSR_START_MARKER, 8'h00);
               write_csr(CSR_END_MARKER, 8'hFF);
            end
            2: begin
               write_csr(CSR_START_MARKER, 8'hFF);
               write_csr(CSR_END_MARKER, 8'h00);
            end
            3: begin
               write_csr(CSR_START_MARKER, 8'h7E);
               write_csr(CSR_END_MARKER, 8'h7E);
            end
            7: begin
               write_csr(CSR_START_MARKER, START_MARKER_RST);
               write_csr(CSR_END_MARKER, END_MARKER_RST);
            end
            default: begin
               write_csr(CSR_START_MARKER, 8'($urandom_range(0, 255)));
               write_csr(CSR_END_MARKER, 8'($urandom_range(0, 255)));
            end
         endcase
         settings_used++;
         send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 55 : 31) : 0;
         recv_stall_pct = (ph % 4 == 2) ? 55 : ((ph % 4 == 3) ? 31 : 0);
         if (ph == 4) begin
            // receiver holds off while short messages keep coming
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_asks++;
            for (int k = 0; k < 30; k++) begin
               if (k % 3 == 0) msg_q = '{sb.start_marker, sb.end_marker};
               else msg_q = '{8'($urandom_range(0, 255))};
               send_message();
            end
         end
         random_messages(130);
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d messages in %0d bytes, %0d marker settings, four idle patterns",
               sb.messages, sb.bytes_taken, settings_used);
      $display("Statuses: ok %0d short %0d frame %0d empty %0d incompl %0d unknown %0d %s",
               sb.status_count[ST_OK], sb.status_count[ST_TOO_SHORT],
               sb.status_count[ST_BAD_FRAME], sb.status_count[ST_EMPTY],
               sb.status_count[ST_INCOMPLETE], sb.status_count[ST_UNKNOWN_CODE],
               $sformatf("cut %0d bad %0d, mismatches %0d", sb.status_count[ST_SHORT_VALUE],
                         sb.status_count[ST_BAD_VALUE], sb.mismatches));
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("framed_param_message_parser_core verification clean");
      end else begin
         $display("framed_param_message_parser_core verification failed");
      end
      $finish;
   end
endmodule
